@@ rtl/drp_pkg.sv @@
// Shared types and constants of the DHCP reply parser.
package drp_pkg;

  localparam int MAX_PACKET_BYTES = 1024;
  localparam int OFFSET_W         = $clog2(MAX_PACKET_BYTES + 1);
  localparam int MIN_REPLY_BYTES  = 240;

  localparam logic [7:0] BOOTP_REPLY  = 8'd2;
  localparam logic [7:0] HTYPE_ETHER  = 8'd1;
  localparam logic [7:0] HLEN_ETHER   = 8'd6;
  localparam logic [7:0] COOKIE_0     = 8'd99;
  localparam logic [7:0] COOKIE_1     = 8'd130;
  localparam logic [7:0] COOKIE_2     = 8'd83;
  localparam logic [7:0] COOKIE_3     = 8'd99;
  localparam logic [15:0] SERVER_PORT = 16'd67;
  localparam logic [15:0] CLIENT_PORT = 16'd68;

  localparam logic [7:0] OPT_PAD      = 8'd0;
  localparam logic [7:0] OPT_END      = 8'd255;
  localparam logic [7:0] OPT_SUBNET   = 8'd1;
  localparam logic [7:0] OPT_ROUTER   = 8'd3;
  localparam logic [7:0] OPT_DNS      = 8'd6;
  localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
  localparam logic [7:0] OPT_SERVER   = 8'd54;

  localparam logic [7:0] MSG_OFFER    = 8'd2;
  localparam logic [7:0] MSG_ACK      = 8'd5;
  localparam logic [7:0] MSG_NAK      = 8'd6;

  // configuration register indexes
  localparam logic [1:0] REG_CLIENT_MAC = 2'd0;
  localparam logic [1:0] REG_XID        = 2'd1;
  localparam logic [1:0] REG_PHASE      = 2'd2;

  localparam logic [1:0] PHASE_SELECTING  = 2'd1;
  localparam logic [1:0] PHASE_REQUESTING = 2'd2;

  localparam logic [1:0] VERDICT_IGNORED = 2'd0;
  localparam logic [1:0] VERDICT_NO_TYPE = 2'd1;
  localparam logic [1:0] VERDICT_UPDATED = 2'd2;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_OFFER = 2'd1;
  localparam logic [1:0] KIND_ACK   = 2'd2;
  localparam logic [1:0] KIND_NAK   = 2'd3;

  // flag bit positions for options of interest
  localparam int F_TYPE   = 0;
  localparam int F_SERVER = 1;
  localparam int F_MASK   = 2;
  localparam int F_ROUTER = 3;
  localparam int F_DNS1   = 4;
  localparam int F_DNS2   = 5;

  typedef enum logic [2:0] {
    OPT_CODE = 3'b001,
    OPT_LEN  = 3'b010,
    OPT_DATA = 3'b100
  } opt_state_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] source_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [1:0]  reply_kind;
    logic [31:0] offered_addr;
    logic [31:0] server_addr;
    logic [31:0] subnet_mask;
    logic [31:0] router_addr;
    logic [31:0] dns_first;
    logic [31:0] dns_second;
  } out_item_t;

  typedef struct packed {
    logic [31:0] offered_addr;
    logic [31:0] server_addr;
    logic [31:0] subnet_mask;
    logic [31:0] router_addr;
    logic [31:0] dns_first;
    logic [31:0] dns_second;
  } lease_t;

endpackage

@@ rtl/dhcp_reply_parser_top.sv @@
// DHCP client reply parser: header checks, option walk and lease commit.
//
// The block takes one byte of a DHCP reply's UDP payload per request, at up
// to one request every cycle, and works on it in that same cycle: header
// checks, the option walk and the lease commit are short compare/shift logic
// feeding the per-packet state registers and the result register. Requests
// that are not the last byte of a packet produce nothing. The last byte (with
// source IP and ports sampled alongside it) produces exactly one result,
// visible on out_valid the cycle after acceptance and held in the result
// register until taken. The result register decouples the two sides: in_ready
// is high whenever that register is empty or is being emptied in the same
// cycle, so a stream of bytes runs at one per cycle as long as results are
// taken when offered. Each result carries the verdict, the reply kind and
// the held lease values after the packet. Configuration writes (client MAC,
// transaction id, phase) take effect at the edge they are presented;
// writing the transaction id clears the held lease. Write them only while the
// block is idle.
module dhcp_reply_parser_top
  import drp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        write_enable,
  input  logic [1:0]  write_index,
  input  logic [47:0] write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  // configuration
  logic [47:0] client_mac;
  logic [31:0] transaction_id;
  logic [1:0]  client_phase;

  // per-packet state
  logic [OFFSET_W-1:0] byte_offset, byte_offset_next;
  logic                header_good, header_good_next;
  opt_state_t          opt_state, opt_state_next;
  logic [7:0]          opt_code, opt_code_next;
  logic [7:0]          opt_length, opt_length_next;
  logic [7:0]          opt_remaining, opt_remaining_next;
  logic                opt_done, opt_done_next;
  logic [63:0]         opt_data, opt_data_next;
  logic [5:0]          found, found_next;
  logic [4:0]          seen, seen_next;
  logic [7:0]          pending_type, pending_type_next;
  lease_t              pending, pending_next;

  // held lease across packets
  lease_t held, held_next;

  logic      accept;
  logic      result_load;
  out_item_t result;

  // option completion helpers
  logic        opt_complete;
  logic [3:0]  opt_n;
  logic [31:0] first4;
  logic        wanted;
  logic [4:0]  code_bit;
  logic        packet_ok;
  logic [7:0]  b;

  assign accept      = in_valid && in_ready;
  assign in_ready    = !out_valid || out_ready;
  assign result_load = accept && in_data.last_byte;
  assign b           = in_data.data_byte;

  always_comb begin
    byte_offset_next   = byte_offset;
    header_good_next   = header_good;
    opt_state_next     = opt_state;
    opt_code_next      = opt_code;
    opt_length_next    = opt_length;
    opt_remaining_next = opt_remaining;
    opt_done_next      = opt_done;
    opt_data_next      = opt_data;
    found_next         = found;
    seen_next          = seen;
    pending_type_next  = pending_type;
    pending_next       = pending;
    held_next          = held;
    opt_complete       = 1'b0;
    opt_n              = 4'd0;
    first4             = 32'd0;
    wanted             = 1'b0;
    code_bit           = 5'd0;
    packet_ok          = 1'b0;
    result             = '0;

    // Header bytes and option walk
    if (byte_offset >= OFFSET_W'(MAX_PACKET_BYTES)) begin
      header_good_next = 1'b0;
    end else begin
      byte_offset_next = byte_offset + OFFSET_W'(1);
      case (byte_offset) inside
        0: if (b != BOOTP_REPLY) header_good_next = 1'b0;
        1: if (b != HTYPE_ETHER) header_good_next = 1'b0;
        2: if (b != HLEN_ETHER)  header_good_next = 1'b0;
        [4:7]: begin
          case (byte_offset[1:0])
            2'd0:    if (b != transaction_id[31:24]) header_good_next = 1'b0;
            2'd1:    if (b != transaction_id[23:16]) header_good_next = 1'b0;
            2'd2:    if (b != transaction_id[15:8])  header_good_next = 1'b0;
            default: if (b != transaction_id[7:0])   header_good_next = 1'b0;
          endcase
        end
        [16:19]: pending_next.offered_addr = {pending.offered_addr[23:0], b};
        [28:33]: begin
          case (byte_offset[2:0])
            3'd4:    if (b != client_mac[47:40]) header_good_next = 1'b0;
            3'd5:    if (b != client_mac[39:32]) header_good_next = 1'b0;
            3'd6:    if (b != client_mac[31:24]) header_good_next = 1'b0;
            3'd7:    if (b != client_mac[23:16]) header_good_next = 1'b0;
            3'd0:    if (b != client_mac[15:8])  header_good_next = 1'b0;
            default: if (b != client_mac[7:0])   header_good_next = 1'b0;
          endcase
        end
        236: if (b != COOKIE_0) header_good_next = 1'b0;
        237: if (b != COOKIE_1) header_good_next = 1'b0;
        238: if (b != COOKIE_2) header_good_next = 1'b0;
        239: if (b != COOKIE_3) header_good_next = 1'b0;
        default: ;
      endcase

      if (byte_offset >= OFFSET_W'(MIN_REPLY_BYTES) && !opt_done) begin
        unique case (opt_state)
          OPT_CODE: begin
            if (b == OPT_END) begin
              opt_done_next = 1'b1;
            end else if (b != OPT_PAD) begin
              opt_code_next  = b;
              opt_state_next = OPT_LEN;
            end
          end
          OPT_LEN: begin
            opt_length_next    = b;
            opt_remaining_next = b;
            opt_data_next      = 64'd0;
            if (b == 8'd0) begin
              opt_complete   = 1'b1;
              opt_state_next = OPT_CODE;
            end else begin
              opt_state_next = OPT_DATA;
            end
          end
          OPT_DATA: begin
            // keep only the first eight data bytes
            if (opt_length - opt_remaining < 8'd8) opt_data_next = {opt_data[55:0], b};
            opt_remaining_next = opt_remaining - 8'd1;
            if (opt_remaining_next == 8'd0) begin
              opt_complete   = 1'b1;
              opt_state_next = OPT_CODE;
            end
          end
          default: opt_state_next = OPT_CODE;
        endcase
      end
    end

    // Option finished: first occurrence of a wanted code decides
    if (opt_complete) begin
      case (opt_code)
        OPT_MSG_TYPE: begin wanted = 1'b1; code_bit[F_TYPE]   = 1'b1; end
        OPT_SERVER:   begin wanted = 1'b1; code_bit[F_SERVER] = 1'b1; end
        OPT_SUBNET:   begin wanted = 1'b1; code_bit[F_MASK]   = 1'b1; end
        OPT_ROUTER:   begin wanted = 1'b1; code_bit[F_ROUTER] = 1'b1; end
        OPT_DNS:      begin wanted = 1'b1; code_bit[F_DNS1]   = 1'b1; end
        default:      wanted = 1'b0;
      endcase
      opt_n = (opt_length_next >= 8'd8) ? 4'd8 : opt_length_next[3:0];
      case (opt_n)
        4'd4:    first4 = opt_data_next[31:0];
        4'd5:    first4 = opt_data_next[39:8];
        4'd6:    first4 = opt_data_next[47:16];
        4'd7:    first4 = opt_data_next[55:24];
        4'd8:    first4 = opt_data_next[63:32];
        default: first4 = 32'd0;
      endcase
      if (wanted && (seen & code_bit) == 5'd0) begin
        seen_next = seen | code_bit;
        if (code_bit[F_TYPE]) begin
          if (opt_length_next == 8'd1) begin
            pending_type_next = opt_data_next[7:0];
            found_next[F_TYPE] = 1'b1;
          end
        end else if (code_bit[F_SERVER]) begin
          if (opt_length_next == 8'd4) begin
            pending_next.server_addr = first4;
            found_next[F_SERVER] = 1'b1;
          end
        end else if (code_bit[F_MASK]) begin
          if (opt_length_next == 8'd4) begin
            pending_next.subnet_mask = first4;
            found_next[F_MASK] = 1'b1;
          end
        end else if (code_bit[F_ROUTER]) begin
          if (opt_length_next >= 8'd4) begin
            pending_next.router_addr = first4;
            found_next[F_ROUTER] = 1'b1;
          end
        end else begin
          if (opt_length_next >= 8'd4) begin
            pending_next.dns_first = first4;
            found_next[F_DNS1] = 1'b1;
          end
          if (opt_length_next >= 8'd8) begin
            pending_next.dns_second = opt_data_next[31:0];
            found_next[F_DNS2] = 1'b1;
          end
        end
      end
    end

    // Packet end: commit and build the result
    if (in_data.last_byte) begin
      packet_ok = (client_phase == PHASE_SELECTING || client_phase == PHASE_REQUESTING) &&
                  in_data.source_port == SERVER_PORT && in_data.dest_port == CLIENT_PORT &&
                  byte_offset_next >= OFFSET_W'(MIN_REPLY_BYTES) && header_good_next;
      result.verdict    = VERDICT_IGNORED;
      result.reply_kind = KIND_NONE;
      if (packet_ok) begin
        if (!found_next[F_TYPE]) begin
          result.verdict = VERDICT_NO_TYPE;
        end else begin
          result.verdict         = VERDICT_UPDATED;
          held_next.offered_addr = pending_next.offered_addr;
          held_next.server_addr  = found_next[F_SERVER] ? pending_next.server_addr
                                                        : in_data.source_ip;
          if (found_next[F_MASK])   held_next.subnet_mask = pending_next.subnet_mask;
          if (found_next[F_ROUTER]) held_next.router_addr = pending_next.router_addr;
          if (found_next[F_DNS1])   held_next.dns_first   = pending_next.dns_first;
          if (found_next[F_DNS2])   held_next.dns_second  = pending_next.dns_second;
          if (pending_type_next == MSG_OFFER && client_phase == PHASE_SELECTING)
            result.reply_kind = KIND_OFFER;
          else if (pending_type_next == MSG_ACK && client_phase == PHASE_REQUESTING)
            result.reply_kind = KIND_ACK;
          else if (pending_type_next == MSG_NAK)
            result.reply_kind = KIND_NAK;
        end
      end
      result.offered_addr = held_next.offered_addr;
      result.server_addr  = held_next.server_addr;
      result.subnet_mask  = held_next.subnet_mask;
      result.router_addr  = held_next.router_addr;
      result.dns_first    = held_next.dns_first;
      result.dns_second   = held_next.dns_second;

      // drop all per-packet state for the next packet
      byte_offset_next   = '0;
      header_good_next   = 1'b1;
      opt_state_next     = OPT_CODE;
      opt_code_next      = 8'd0;
      opt_length_next    = 8'd0;
      opt_remaining_next = 8'd0;
      opt_done_next      = 1'b0;
      opt_data_next      = 64'd0;
      found_next         = 6'd0;
      seen_next          = 5'd0;
      pending_type_next  = 8'd0;
      pending_next       = '0;
    end
  end

  // Per-packet state and held lease advance only on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset   <= '0;
      header_good   <= 1'b1;
      opt_state     <= OPT_CODE;
      opt_code      <= 8'd0;
      opt_length    <= 8'd0;
      opt_remaining <= 8'd0;
      opt_done      <= 1'b0;
      opt_data      <= 64'd0;
      found         <= 6'd0;
      seen          <= 5'd0;
      pending_type  <= 8'd0;
      pending       <= '0;
      held          <= '0;
    end else begin
      if (accept) begin
        byte_offset   <= byte_offset_next;
        header_good   <= header_good_next;
        opt_state     <= opt_state_next;
        opt_code      <= opt_code_next;
        opt_length    <= opt_length_next;
        opt_remaining <= opt_remaining_next;
        opt_done      <= opt_done_next;
        opt_data      <= opt_data_next;
        found         <= found_next;
        seen          <= seen_next;
        pending_type  <= pending_type_next;
        pending       <= pending_next;
        held          <= held_next;
      end
      // a new transaction id drops the old lease
      if (write_enable && write_index == REG_XID) held <= '0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      client_mac     <= 48'd0;
      transaction_id <= 32'd0;
      client_phase   <= 2'd0;
    end else if (write_enable) begin
      unique case (write_index)
        REG_CLIENT_MAC: client_mac     <= write_data;
        REG_XID:        transaction_id <= write_data[31:0];
        REG_PHASE:      client_phase   <= write_data[1:0];
        default: ;
      endcase
    end
  end

  // Result register: load on the last byte, hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) out_data <= result;
  end

endmodule

@@ rtl/drp_checker.sv @@
// Port-level checks for the DHCP reply parser, bound to the top level.
module drp_checker
  import drp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // the last byte of a packet always yields a result
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.last_byte |=> out_valid)
    else $error("no result after last byte");

  // nothing but a last byte yields a result
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && in_ready && in_data.last_byte) && (!out_valid || out_ready)
    |=> !out_valid)
    else $error("result without last byte");

  // the result register never blocks the input when empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // only an updated lease can report a reply kind
  a_kind_needs_update: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.verdict != VERDICT_UPDATED |-> out_data.reply_kind == KIND_NONE)
    else $error("reply kind without lease update");

endmodule

bind dhcp_reply_parser_top drp_checker u_drp_checker (.*);

@@ bench/dhcp_reply_parser_checker.sv @@
// Reply checker for the DHCP reply parser: tracks requests, predicts results and compares them.
module dhcp_reply_parser_checker
  import drp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        write_enable,
  input  logic [1:0]  write_index,
  input  logic [47:0] write_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  output int          errors,
  output int          replies_open
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic [47:0] cfg_mac;
  logic [31:0] cfg_xid;
  logic [1:0]  cfg_phase;

  // per-packet parse state
  int unsigned pos;
  bit          hdr_ok;
  opt_state_t  walk;
  logic [7:0]  opt_id;
  logic [7:0]  opt_size;
  logic [7:0]  opt_left;
  logic [63:0] opt_bytes;
  bit          walk_over;
  logic [5:0]  have;      // usable options, bits at the package flag positions
  logic [4:0]  visited;   // wanted codes already met once
  logic [7:0]  msg_kind;
  logic [31:0] cand [6];  // yiaddr, then server, mask, router, dns1, dns2
  lease_t      lease;

  out_item_t   replies_due [$];

  task automatic clear_packet();
    pos       = 0;
    hdr_ok    = 1'b1;
    walk      = OPT_CODE;
    opt_id    = '0;
    opt_size  = '0;
    opt_left  = '0;
    opt_bytes = '0;
    walk_over = 1'b0;
    have      = '0;
    visited   = '0;
    msg_kind  = '0;
    foreach (cand[i]) cand[i] = '0;
  endtask

  // Keep only the first occurrence of each wanted code, usable or not.
  task automatic close_option();
    int          slot;
    int          n;
    logic [31:0] head4;
    case (opt_id)
      OPT_MSG_TYPE: slot = F_TYPE;
      OPT_SERVER:   slot = F_SERVER;
      OPT_SUBNET:   slot = F_MASK;
      OPT_ROUTER:   slot = F_ROUTER;
      OPT_DNS:      slot = F_DNS1;
      default:      slot = -1;
    endcase
    if (slot < 0) return;
    if (visited[slot]) return;
    visited[slot] = 1'b1;
    n     = (opt_size < 8) ? opt_size : 8;
    head4 = '0;
    if (n >= 4) head4 = opt_bytes >> (8 * (n - 4));
    case (slot)
      F_TYPE: begin
        if (opt_size == 8'd1) begin
          msg_kind     = opt_bytes[7:0];
          have[F_TYPE] = 1'b1;
        end
      end
      F_SERVER, F_MASK: begin
        if (opt_size == 8'd4) begin
          cand[slot] = head4;
          have[slot] = 1'b1;
        end
      end
      F_ROUTER: begin
        if (opt_size >= 8'd4) begin
          cand[F_ROUTER] = head4;
          have[F_ROUTER] = 1'b1;
        end
      end
      default: begin
        if (opt_size >= 8'd4) begin
          cand[F_DNS1] = head4;
          have[F_DNS1] = 1'b1;
        end
        if (opt_size >= 8'd8) begin
          cand[F_DNS2] = opt_bytes[31:0];
          have[F_DNS2] = 1'b1;
        end
      end
    endcase
  endtask

  // Advance the parse by one request; on the last byte, queue the expected reply.
  task automatic absorb_byte(input in_item_t req);
    logic [7:0] b;
    out_item_t  res;
    b = req.data_byte;
    if (pos >= MAX_PACKET_BYTES) begin
      hdr_ok = 1'b0;
    end else begin
      if (pos == 0) begin
        if (b != BOOTP_REPLY) hdr_ok = 1'b0;
      end else if (pos == 1) begin
        if (b != HTYPE_ETHER) hdr_ok = 1'b0;
      end else if (pos == 2) begin
        if (b != HLEN_ETHER) hdr_ok = 1'b0;
      end else if (pos >= 4 && pos <= 7) begin
        if (b != cfg_xid[8 * (7 - pos) +: 8]) hdr_ok = 1'b0;
      end else if (pos >= 16 && pos <= 19) begin
        cand[0] = {cand[0][23:0], b};
      end else if (pos >= 28 && pos <= 33) begin
        if (b != cfg_mac[8 * (33 - pos) +: 8]) hdr_ok = 1'b0;
      end else if (pos == 236) begin
        if (b != COOKIE_0) hdr_ok = 1'b0;
      end else if (pos == 237) begin
        if (b != COOKIE_1) hdr_ok = 1'b0;
      end else if (pos == 238) begin
        if (b != COOKIE_2) hdr_ok = 1'b0;
      end else if (pos == 239) begin
        if (b != COOKIE_3) hdr_ok = 1'b0;
      end else if (pos >= MIN_REPLY_BYTES && !walk_over) begin
        case (walk)
          OPT_CODE: begin
            if (b == OPT_END) begin
              walk_over = 1'b1;
            end else if (b != OPT_PAD) begin
              opt_id = b;
              walk   = OPT_LEN;
            end
          end
          OPT_LEN: begin
            opt_size  = b;
            opt_left  = b;
            opt_bytes = '0;
            if (b == 8'd0) begin
              close_option();
              walk = OPT_CODE;
            end else begin
              walk = OPT_DATA;
            end
          end
          default: begin
            if (opt_size - opt_left < 8'd8) opt_bytes = {opt_bytes[55:0], b};
            opt_left = opt_left - 8'd1;
            if (opt_left == 8'd0) begin
              close_option();
              walk = OPT_CODE;
            end
          end
        endcase
      end
      pos++;
    end
    if (!req.last_byte) return;

    res            = '0;
    res.verdict    = VERDICT_IGNORED;
    res.reply_kind = KIND_NONE;
    if ((cfg_phase == PHASE_SELECTING || cfg_phase == PHASE_REQUESTING) &&
        req.source_port == SERVER_PORT && req.dest_port == CLIENT_PORT &&
        pos >= MIN_REPLY_BYTES && hdr_ok) begin
      if (!have[F_TYPE]) begin
        res.verdict = VERDICT_NO_TYPE;
      end else begin
        res.verdict        = VERDICT_UPDATED;
        lease.offered_addr = cand[0];
        lease.server_addr  = have[F_SERVER] ? cand[F_SERVER] : req.source_ip;
        if (have[F_MASK])   lease.subnet_mask = cand[F_MASK];
        if (have[F_ROUTER]) lease.router_addr = cand[F_ROUTER];
        if (have[F_DNS1])   lease.dns_first   = cand[F_DNS1];
        if (have[F_DNS2])   lease.dns_second  = cand[F_DNS2];
        if (msg_kind == MSG_OFFER && cfg_phase == PHASE_SELECTING)
          res.reply_kind = KIND_OFFER;
        else if (msg_kind == MSG_ACK && cfg_phase == PHASE_REQUESTING)
          res.reply_kind = KIND_ACK;
        else if (msg_kind == MSG_NAK)
          res.reply_kind = KIND_NAK;
      end
    end
    res.offered_addr = lease.offered_addr;
    res.server_addr  = lease.server_addr;
    res.subnet_mask  = lease.subnet_mask;
    res.router_addr  = lease.router_addr;
    res.dns_first    = lease.dns_first;
    res.dns_second   = lease.dns_second;
    replies_due.push_back(res);
    clear_packet();
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_mac   = '0;
      cfg_xid   = '0;
      cfg_phase = '0;
      lease     = '0;
      clear_packet();
      replies_due.delete();
      errors       = 0;
      replies_open = 0;
    end else begin
      if (write_enable) begin
        case (write_index)
          REG_CLIENT_MAC: cfg_mac = write_data;
          REG_XID: begin
            cfg_xid = write_data[31:0];
            lease   = '0;
          end
          REG_PHASE: cfg_phase = write_data[1:0];
          default: ;
        endcase
      end
      // compare before absorbing, so a reply never meets its own expectation
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: unexpected reply %h", $time, out_data);
        end else begin
          out_item_t want;
          want = replies_due.pop_front();
          check_field("verdict", want.verdict, out_data.verdict);
          check_field("reply_kind", want.reply_kind, out_data.reply_kind);
          check_field("offered_addr", want.offered_addr, out_data.offered_addr);
          check_field("server_addr", want.server_addr, out_data.server_addr);
          check_field("subnet_mask", want.subnet_mask, out_data.subnet_mask);
          check_field("router_addr", want.router_addr, out_data.router_addr);
          check_field("dns_first", want.dns_first, out_data.dns_first);
          check_field("dns_second", want.dns_second, out_data.dns_second);
        end
      end
      if (in_valid && in_ready) absorb_byte(in_data);
      replies_open = replies_due.size();
    end
  end

endmodule

@@ bench/dhcp_reply_parser_top_tb.sv @@
// Testbench top for the DHCP reply parser: clock, reset, packet stimulus and verdict.
module dhcp_reply_parser_top_tb;
  import drp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // phase values the package does not name; both leave the client inactive
  localparam logic [1:0] PHASE_INACTIVE = 2'd0;
  localparam logic [1:0] PHASE_SPARE    = 2'd3;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        write_enable = 1'b0;
  logic [1:0]  write_index  = '0;
  logic [47:0] write_data   = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data  = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;

  int errors;
  int replies_open;

  // what the registers hold, so that good packets can be built
  logic [47:0] mac_now   = '0;
  logic [31:0] xid_now   = '0;
  logic [1:0]  phase_now = '0;

  bit in_idle_on  = 1'b1;
  bit out_idle_on = 1'b1;

  logic [7:0] pkt [$];

  // header offsets the block checks; flipping one bit there spoils the header
  int checked_offs [17] = '{0, 1, 2, 4, 5, 6, 7, 28, 29, 30, 31, 32, 33,
                            236, 237, 238, 239};

  dhcp_reply_parser_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

  dhcp_reply_parser_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .errors       (errors),
    .replies_open (replies_open)
  );

  always #5 clk = ~clk;

  // Hang guard: end the run as failed if it never drains.
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: stall in random bursts while idling is enabled.
  int unsigned hold_left = 0;
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (out_idle_on && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      hold_left <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Write one register, then drop the enable before returning so that back-to-back
  // writes never assign write_enable twice in one step.
  task automatic set_reg(input logic [1:0] idx, input logic [47:0] val);
    write_enable <= 1'b1;
    write_index  <= idx;
    write_data   <= val;
    @(posedge clk);
    write_enable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_CLIENT_MAC: mac_now = val;
      REG_XID:        xid_now = val[31:0];
      REG_PHASE:      phase_now = val[1:0];
      default: ;
    endcase
  endtask

  // Hold off requests until every expected reply has been taken, then let
  // the block settle.
  task automatic quiesce();
    in_valid <= 1'b0;
    do @(negedge clk); while (replies_open != 0);
    repeat (3) @(posedge clk);
  endtask

  // Fixed 240-byte BOOTP header with our xid, the given MAC and yiaddr;
  // every unchecked byte is random.
  task automatic make_header(input logic [31:0] yi, input logic [47:0] mac);
    pkt.delete();
    repeat (MIN_REPLY_BYTES) pkt.push_back($urandom_range(0, 255));
    pkt[0] = BOOTP_REPLY;
    pkt[1] = HTYPE_ETHER;
    pkt[2] = HLEN_ETHER;
    for (int i = 0; i < 4; i++) pkt[4 + i]  = xid_now[8 * (3 - i) +: 8];
    for (int i = 0; i < 4; i++) pkt[16 + i] = yi[8 * (3 - i) +: 8];
    for (int i = 0; i < 6; i++) pkt[28 + i] = mac[8 * (5 - i) +: 8];
    pkt[236] = COOKIE_0;
    pkt[237] = COOKIE_1;
    pkt[238] = COOKIE_2;
    pkt[239] = COOKIE_3;
  endtask

  task automatic add_opt(input logic [7:0] code, input int len);
    pkt.push_back(code);
    pkt.push_back(len);
    repeat (len) pkt.push_back($urandom_range(0, 255));
  endtask

  task automatic add_type(input logic [7:0] kind);
    pkt.push_back(OPT_MSG_TYPE);
    pkt.push_back(8'd1);
    pkt.push_back(kind);
  endtask

  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 3))
      0:       return MSG_OFFER;
      1:       return MSG_ACK;
      2:       return MSG_NAK;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // Send pkt[first..stop] one request at a time. Ports and source IP only
  // matter on the final byte of the packet; elsewhere they carry noise.
  task automatic send_bytes(input int first, input int stop, input logic [31:0] sip,
                            input logic [15:0] sp, input logic [15:0] dp);
    in_item_t r;
    bit       took;
    for (int i = first; i <= stop; i++) begin
      r.data_byte   = pkt[i];
      r.last_byte   = (i == pkt.size() - 1);
      r.source_ip   = r.last_byte ? sip : $urandom;
      r.source_port = r.last_byte ? sp : $urandom;
      r.dest_port   = r.last_byte ? dp : $urandom;
      if (in_idle_on && $urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= r;
      // in_ready is stable from the falling edge to the next rising edge
      do begin
        @(negedge clk);
        took = in_ready;
        @(posedge clk);
      end while (!took);
    end
  endtask

  initial begin
    int          seg;
    int          p;
    int          pick;
    int          n;
    int          k;
    logic [31:0] sip;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [47:0] mac_pick;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---------------- directed packets ----------------
    quiesce();
    set_reg(REG_CLIENT_MAC, '1);
    set_reg(REG_XID, '0);
    set_reg(REG_PHASE, PHASE_SELECTING);

    // single byte that is also the last: far too short, ignored
    pkt.delete();
    pkt.push_back(8'hFF);
    send_bytes(0, 0, '1, SERVER_PORT, CLIENT_PORT);

    // bare header, no options: consumed without a message type
    make_header('1, mac_now);
    send_bytes(0, pkt.size() - 1, '0, SERVER_PORT, CLIENT_PORT);

    // full offer with every lease option
    make_header($urandom, mac_now);
    add_type(MSG_OFFER);
    add_opt(OPT_SERVER, 4);
    add_opt(OPT_SUBNET, 4);
    add_opt(OPT_ROUTER, 8);
    add_opt(OPT_DNS, 8);
    pkt.push_back(OPT_END);
    send_bytes(0, pkt.size() - 1, $urandom, SERVER_PORT, CLIENT_PORT);

    // ack while selecting (no kind reported), pads, bad server id length
    // followed by a good one that must lose, and options after the end mark
    make_header($urandom, mac_now);
    pkt.push_back(OPT_PAD);
    pkt.push_back(OPT_PAD);
    add_type(MSG_ACK);
    add_opt(OPT_SERVER, 3);
    add_opt(OPT_SERVER, 4);
    add_opt(OPT_DNS, 4);
    add_opt(OPT_ROUTER, 4);
    pkt.push_back(OPT_END);
    add_type(MSG_NAK);
    add_opt(OPT_SUBNET, 4);
    send_bytes(0, pkt.size() - 1, $urandom, SERVER_PORT, CLIENT_PORT);

    // nak with a long DNS list and a router option cut off by packet end
    make_header($urandom, mac_now);
    add_type(MSG_NAK);
    add_opt(OPT_DNS, 12);
    pkt.push_back(OPT_ROUTER);
    pkt.push_back(8'd10);
    repeat (3) pkt.push_back($urandom_range(0, 255));
    send_bytes(0, pkt.size() - 1, $urandom, SERVER_PORT, CLIENT_PORT);

    // first type option has the wrong length, so the good one after it is
    // ignored; also a zero-length mask
    make_header($urandom, mac_now);
    add_opt(OPT_MSG_TYPE, 2);
    add_type(MSG_OFFER);
    add_opt(OPT_SUBNET, 0);
    pkt.push_back(OPT_END);
    send_bytes(0, pkt.size() - 1, $urandom, SERVER_PORT, CLIENT_PORT);

    // wrong source port, then wrong destination port
    make_header($urandom, mac_now);
    add_type(MSG_OFFER);
    send_bytes(0, pkt.size() - 1, $urandom, SERVER_PORT - 16'd1, CLIENT_PORT);
    make_header($urandom, mac_now);
    add_type(MSG_OFFER);
    send_bytes(0, pkt.size() - 1, $urandom, SERVER_PORT, CLIENT_PORT + 16'd1);

    // one byte short of a full header
    make_header($urandom, mac_now);
    void'(pkt.pop_back());
    send_bytes(0, pkt.size() - 1, $urandom, SERVER_PORT, CLIENT_PORT);

    // broken magic cookie, then a wrong xid byte
    make_header($urandom, mac_now);
    add_type(MSG_OFFER);
    pkt[237] = COOKIE_1 + 8'd1;
    send_bytes(0, pkt.size() - 1, $urandom, SERVER_PORT, CLIENT_PORT);
    make_header($urandom, mac_now);
    add_type(MSG_OFFER);
    pkt[7] = pkt[7] ^ 8'h01;
    send_bytes(0, pkt.size() - 1, $urandom, SERVER_PORT, CLIENT_PORT);

    // requesting: ack, an offer that reports nothing, and a nak
    quiesce();
    set_reg(REG_XID, '1);
    set_reg(REG_CLIENT_MAC, '0);
    set_reg(REG_PHASE, PHASE_REQUESTING);
    make_header($urandom, mac_now);
    add_type(MSG_ACK);
    add_opt(OPT_SUBNET, 4);
    send_bytes(0, pkt.size() - 1, $urandom, SERVER_PORT, CLIENT_PORT);
    make_header($urandom, mac_now);
    add_type(MSG_OFFER);
    send_bytes(0, pkt.size() - 1, $urandom, SERVER_PORT, CLIENT_PORT);
    make_header($urandom, mac_now);
    add_type(MSG_NAK);
    add_opt(OPT_SERVER, 4);
    send_bytes(0, pkt.size() - 1, $urandom, SERVER_PORT, CLIENT_PORT);

    // phase three and inactive: good packets are ignored
    quiesce();
    set_reg(REG_PHASE, PHASE_SPARE);
    make_header($urandom, mac_now);
    add_type(MSG_ACK);
    send_bytes(0, pkt.size() - 1, $urandom, SERVER_PORT, CLIENT_PORT);
    quiesce();
    set_reg(REG_PHASE, PHASE_INACTIVE);
    make_header($urandom, mac_now);
    add_type(MSG_NAK);
    send_bytes(0, pkt.size() - 1, $urandom, SERVER_PORT, CLIENT_PORT);

    // registers changed mid-packet: the MAC before its bytes arrive, the
    // phase just before the last byte
    quiesce();
    set_reg(REG_PHASE, PHASE_SELECTING);
    mac_pick = {$urandom, $urandom};
    make_header($urandom, mac_pick);
    add_type(MSG_ACK);
    pkt.push_back(OPT_END);
    send_bytes(0, 19, $urandom, SERVER_PORT, CLIENT_PORT);
    quiesce();
    set_reg(REG_CLIENT_MAC, mac_pick);
    send_bytes(20, pkt.size() - 2, $urandom, SERVER_PORT, CLIENT_PORT);
    quiesce();
    set_reg(REG_PHASE, PHASE_REQUESTING);
    send_bytes(pkt.size() - 1, pkt.size() - 1, $urandom, SERVER_PORT, CLIENT_PORT);

    // oversize packet: bytes past the size limit spoil it
    quiesce();
    set_reg(REG_PHASE, PHASE_SELECTING);
    make_header($urandom, mac_now);
    add_type(MSG_OFFER);
    while (pkt.size() < MAX_PACKET_BYTES + 6) pkt.push_back(OPT_PAD);
    send_bytes(0, pkt.size() - 1, $urandom, SERVER_PORT, CLIENT_PORT);

    // ---------------- random packets ----------------
    for (seg = 0; seg < 6; seg++) begin
      quiesce();
      // last segment runs with no idling on either side
      in_idle_on  = (seg != 5) && ($urandom_range(0, 3) != 0);
      out_idle_on = (seg != 5) && ($urandom_range(0, 3) != 0);
      mac_pick = {$urandom, $urandom};
      if (seg == 1) mac_pick = '0;
      if (seg == 2) mac_pick = '1;
      set_reg(REG_CLIENT_MAC, mac_pick);
      if (seg == 3)
        set_reg(REG_XID, '0);
      else if (seg == 4)
        set_reg(REG_XID, '1);
      else if (seg == 0 || $urandom_range(0, 1) == 0)
        set_reg(REG_XID, $urandom);
      if ($urandom_range(0, 9) < 8)
        set_reg(REG_PHASE, $urandom_range(0, 1) ? PHASE_SELECTING : PHASE_REQUESTING);
      else
        set_reg(REG_PHASE, $urandom_range(0, 1) ? PHASE_INACTIVE : PHASE_SPARE);

      for (p = 0; p < 9; p++) begin
        // pause the sender until everything expected has arrived
        if (p == 4 && $urandom_range(0, 1) == 0) quiesce();
        pick = $urandom_range(0, 99);
        sip  = $urandom;
        sp   = SERVER_PORT;
        dp   = CLIENT_PORT;
        if (pick < 8) begin
          // noise: a short burst of random bytes
          pkt.delete();
          n = $urandom_range(1, 40);
          repeat (n) pkt.push_back($urandom_range(0, 255));
        end else begin
          make_header($urandom, mac_now);
          if (pick < 16) begin
            k = checked_offs[$urandom_range(0, 16)];
            pkt[k] = pkt[k] ^ (8'd1 << $urandom_range(0, 7));
          end else if (pick < 20) begin
            if ($urandom_range(0, 1))
              sp = SERVER_PORT ^ (16'd1 << $urandom_range(0, 15));
            else
              dp = CLIENT_PORT ^ (16'd1 << $urandom_range(0, 15));
          end
          if ($urandom_range(0, 9) < 8) add_type(pick_type());
          n = $urandom_range(0, 7);
          repeat (n) begin
            case ($urandom_range(0, 7))
              0: repeat ($urandom_range(1, 3)) pkt.push_back(OPT_PAD);
              1: begin
                if ($urandom_range(0, 1)) add_type(pick_type());
                else add_opt(OPT_MSG_TYPE, $urandom_range(0, 3));
              end
              2: add_opt(OPT_SERVER,
                         $urandom_range(0, 3) == 0 ? $urandom_range(0, 6) : 4);
              3: add_opt(OPT_SUBNET,
                         $urandom_range(0, 3) == 0 ? $urandom_range(0, 6) : 4);
              4: add_opt(OPT_ROUTER, $urandom_range(0, 3) == 0 ?
                         $urandom_range(0, 3) : $urandom_range(4, 12));
              5: add_opt(OPT_DNS, $urandom_range(0, 3) == 0 ?
                         $urandom_range(0, 7) : 4 * $urandom_range(1, 3));
              default: add_opt($urandom_range(1, 254), $urandom_range(0, 20));
            endcase
          end
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: begin
              pkt.push_back(OPT_END);
              repeat ($urandom_range(0, 12)) pkt.push_back($urandom_range(0, 255));
            end
            7: begin
              // final option cut off by the end of the packet
              k = $urandom_range(1, 30);
              pkt.push_back($urandom_range(0, 1) ? OPT_DNS : OPT_ROUTER);
              pkt.push_back(k);
              repeat ($urandom_range(0, k - 1)) pkt.push_back($urandom_range(0, 255));
            end
            default: ;
          endcase
          // a few packets end before the header is complete
          if (pick >= 20 && pick < 24) begin
            k = $urandom_range(200, 239);
            while (pkt.size() > k) void'(pkt.pop_back());
          end
        end
        send_bytes(0, pkt.size() - 1, sip, sp, dp);
      end
    end

    // drain, let the block settle, then judge
    quiesce();
    repeat (10) @(posedge clk);
    if (errors == 0 && replies_open == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/drp_pkg.sv
rtl/dhcp_reply_parser_top.sv
rtl/drp_checker.sv
bench/dhcp_reply_parser_checker.sv
bench/dhcp_reply_parser_top_tb.sv
